>>> hdl/chipset_shadow_and_a20_ports_top_defines.svh
// Assertion macros used by the chipset port block top module.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef CHIPSET_SHADOW_AND_A20_PORTS_TOP_DEFINES_SVH
`define CHIPSET_SHADOW_AND_A20_PORTS_TOP_DEFINES_SVH

// same-cycle implication
`define CSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("chipset port block check failed");

// next-cycle implication
`define CSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("chipset port block check failed");

`endif

>>> hdl/csa20_pkg.sv
// Types, port codes and helpers for the chipset port block.
// No dependencies; used by every module of the block.
package csa20_pkg;

    localparam int LAST_WRITABLE_INDEX = 36;
    localparam int CFG_DEPTH = LAST_WRITABLE_INDEX + 1;
    localparam int CFG_AW = $clog2(CFG_DEPTH);

    localparam logic [15:0] PORT_92       = 16'h0092;
    localparam logic [15:0] PORT_INDEX    = 16'h00EC;
    localparam logic [15:0] PORT_DATA     = 16'h00ED;
    localparam logic [15:0] PORT_A20_OPEN = 16'h00EE;
    localparam logic [15:0] PORT_RESET    = 16'h00EF;

    localparam logic [7:0] CHIP_ID            = 8'h90;
    localparam logic [7:0] UNMAPPED_DATA      = 8'hFF;
    localparam logic [7:0] FIRST_SHADOW_INDEX = 8'h0D;
    localparam logic [7:0] LAST_SHADOW_INDEX  = 8'h12;

    typedef struct packed {
        logic        is_write;
        logic [15:0] port_address;
        logic [7:0]  write_data;
    } access_t;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] read_data;
    } cfg_view_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       a20_gate;
        logic       cpu_reset;
        logic       map_update;
        logic [2:0] map_region;
        logic [3:0] read_internal;
        logic [3:0] write_internal;
    } result_t;

    function automatic logic idx_writable(input logic [7:0] idx);
        return (idx != 8'd0) && (idx <= 8'(LAST_WRITABLE_INDEX));
    endfunction

    function automatic logic idx_shadow(input logic [7:0] idx);
        return (idx >= FIRST_SHADOW_INDEX) && (idx <= LAST_SHADOW_INDEX);
    endfunction

endpackage

>>> hdl/chipset_shadow_and_a20_ports_top.sv
// Chipset port block: takes one I/O access word per cycle and returns one result word for
// each. A word is held in the input register, is decoded against the port 92,
// A20 and configuration state, and lands in the result register; its result is offered from
// the result register, and a new word is accepted every cycle while results are taken.
// The configuration bytes live in a small memory with a valid flag per entry, so reset is
// immediate with no clearing pass; the byte at the current index is fetched when the index
// is written, so a data-port read needs no memory access of its own.
// Depends on csa20_pkg, csa20_cfg, csa20_ports and the assertion macros header.
`include "chipset_shadow_and_a20_ports_top_defines.svh"

module chipset_shadow_and_a20_ports_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [15:0] s_port_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_a20_gate,
    output logic        m_cpu_reset,
    output logic        m_map_update,
    output logic [2:0]  m_map_region,
    output logic [3:0]  m_read_internal,
    output logic [3:0]  m_write_internal
);

    logic                 in_vld_reg;
    csa20_pkg::access_t   acc_reg;
    logic                 out_vld_reg;
    csa20_pkg::result_t   res_reg;
    csa20_pkg::result_t   res;
    csa20_pkg::cfg_view_t cfg_view;
    logic                 advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            acc_reg.is_write     <= s_operation;
            acc_reg.port_address <= s_port_address;
            acc_reg.write_data   <= s_write_data;
        end
    end

    csa20_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .acc     (acc_reg),
        .view    (cfg_view)
    );

    csa20_ports u_ports (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .acc     (acc_reg),
        .cfg     (cfg_view),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_read_data      = res_reg.read_data;
    assign m_a20_gate       = res_reg.a20_gate;
    assign m_cpu_reset      = res_reg.cpu_reset;
    assign m_map_update     = res_reg.map_update;
    assign m_map_region     = res_reg.map_region;
    assign m_read_internal  = res_reg.read_internal;
    assign m_write_internal = res_reg.write_internal;

    `CSA_ASSERT_NOW(a_ready_when_empty, !out_vld_reg, s_ready)
    `CSA_ASSERT_NOW(a_update_is_write, m_valid && m_map_update,
        (m_read_data == 8'd0) && !m_cpu_reset && (m_map_region <= 3'd5))
    `CSA_ASSERT_NOW(a_no_update_quiet, m_valid && !m_map_update,
        (m_map_region == 3'd0) && (m_read_internal == 4'd0) && (m_write_internal == 4'd0))
    `CSA_ASSERT_NEXT(a_result_follows, advance, m_valid)

endmodule

>>> hdl/csa20_cfg.sv
// Configuration index register and configuration byte store.
// Depends on csa20_pkg; keeps the byte at the current index ready for reads.
module csa20_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  csa20_pkg::access_t  acc,
    output csa20_pkg::cfg_view_t view
);

    logic [7:0]                      index_reg;
    logic [csa20_pkg::CFG_DEPTH-1:0] vld_reg;
    logic [7:0]                      mem [csa20_pkg::CFG_DEPTH];
    logic [7:0]                      mem_q_reg;
    logic [7:0]                      byte_reg;
    logic                            use_mem_reg;
    logic                            wr_index;
    logic                            wr_data;
    logic                            new_idx_ok;
    logic [csa20_pkg::CFG_AW-1:0]    new_addr;
    logic [csa20_pkg::CFG_AW-1:0]    cur_addr;

    assign wr_index   = fire && acc.is_write && (acc.port_address == csa20_pkg::PORT_INDEX);
    assign wr_data    = fire && acc.is_write && (acc.port_address == csa20_pkg::PORT_DATA)
                        && csa20_pkg::idx_writable(index_reg);
    assign new_idx_ok = csa20_pkg::idx_writable(acc.write_data);
    assign new_addr   = acc.write_data[csa20_pkg::CFG_AW-1:0];
    assign cur_addr   = index_reg[csa20_pkg::CFG_AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_data) begin
            mem[cur_addr] <= acc.write_data;
        end
        if (wr_index && new_idx_ok) begin
            mem_q_reg <= mem[new_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg   <= 8'd0;
            vld_reg     <= '0;
            byte_reg    <= csa20_pkg::CHIP_ID;
            use_mem_reg <= 1'b0;
        end else if (wr_index) begin
            index_reg   <= acc.write_data;
            use_mem_reg <= new_idx_ok && vld_reg[new_addr];
            byte_reg    <= (acc.write_data == 8'd0) ? csa20_pkg::CHIP_ID : 8'd0;
        end else if (wr_data) begin
            vld_reg[cur_addr] <= 1'b1;
            use_mem_reg       <= 1'b0;
            byte_reg          <= acc.write_data;
        end
    end

    assign view.index     = index_reg;
    assign view.read_data = use_mem_reg ? mem_q_reg : byte_reg;

endmodule

>>> hdl/csa20_ports.sv
// Port 92, fast A20 gate and result word decode for one bus access.
// Depends on csa20_pkg and the configuration view from csa20_cfg.
module csa20_ports (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  csa20_pkg::access_t   acc,
    input  csa20_pkg::cfg_view_t cfg,
    output csa20_pkg::result_t   res
);

    logic [7:0] port92_reg;
    logic [7:0] port92_next;
    logic       a20_reg;
    logic       a20_next;

    always_comb begin
        port92_next = port92_reg;
        a20_next    = a20_reg;
        res         = '0;
        if (acc.is_write) begin
            unique case (acc.port_address)
                csa20_pkg::PORT_92: begin
                    a20_next      = acc.write_data[1];
                    res.cpu_reset = ~port92_reg[0] & acc.write_data[0];
                    port92_next   = acc.write_data;
                end
                csa20_pkg::PORT_DATA: begin
                    if (csa20_pkg::idx_writable(cfg.index) && csa20_pkg::idx_shadow(cfg.index)) begin
                        res.map_update     = 1'b1;
                        res.map_region     = 3'(cfg.index - csa20_pkg::FIRST_SHADOW_INDEX);
                        res.read_internal  = {acc.write_data[7], acc.write_data[5],
                                              acc.write_data[3], acc.write_data[1]};
                        res.write_internal = {acc.write_data[6], acc.write_data[4],
                                              acc.write_data[2], acc.write_data[0]};
                    end
                end
                csa20_pkg::PORT_A20_OPEN: begin
                    if (a20_reg) begin
                        port92_next[1] = 1'b0;
                        a20_next       = 1'b0;
                    end
                end
                default: ;
            endcase
        end else begin
            res.read_data = csa20_pkg::UNMAPPED_DATA;
            unique case (acc.port_address)
                csa20_pkg::PORT_92:    res.read_data = port92_reg;
                csa20_pkg::PORT_INDEX: res.read_data = cfg.index;
                csa20_pkg::PORT_DATA:  res.read_data = cfg.read_data;
                csa20_pkg::PORT_A20_OPEN: begin
                    if (!a20_reg) begin
                        port92_next[1] = 1'b1;
                        a20_next       = 1'b1;
                    end
                end
                csa20_pkg::PORT_RESET: res.cpu_reset = 1'b1;
                default: ;
            endcase
        end
        res.a20_gate = a20_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port92_reg <= 8'd0;
            a20_reg    <= 1'b0;
        end else if (fire) begin
            port92_reg <= port92_next;
            a20_reg    <= a20_next;
        end
    end

endmodule
